>>> src/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants shared by the transport position clock modules.
// ----------------------------------------------------------------------------
package tpc_pkg;

   typedef enum logic [1:0] {
      FUNC_ADVANCE     = 2'd0,
      FUNC_SEEK_SAMPLE = 2'd1,
      FUNC_SEEK_POS    = 2'd2,
      FUNC_NONE        = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV_POS,
      ST_RND_POS,
      ST_CMT_POS,
      ST_SEC_LOAD,
      ST_DIV_SEC,
      ST_RND_SEC,
      ST_PUSH
   } state_type;

   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] CSR_TEMPO       = 2'd1;
   localparam logic [1:0] CSR_RUN         = 2'd2;
   localparam logic [1:0] CSR_NONE        = 2'd3;

   localparam logic [17:0] RATE_MIN   = 18'd8000;
   localparam logic [17:0] RATE_MAX   = 18'd192000;
   localparam logic [17:0] RATE_RESET = 18'd48000;
   localparam logic [24:0] TEMPO_MIN   = 25'd1310720;
   localparam logic [24:0] TEMPO_MAX   = 25'd26214400;
   localparam logic [24:0] TEMPO_RESET = 25'd7864320;

   localparam logic [62:0] MAX63 = {63{1'b1}};
   localparam logic [63:0] ALL64 = {64{1'b1}};

   typedef struct packed {
      logic load;
      logic mul_step;
      logic div_load_pos;
      logic sec_load;
      logic div_step;
      logic round;
      logic pos_commit;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic needs_pos;
      logic mul_last;
      logic div_last;
   } status_type;

endpackage

>>> src/tpc_ctrl.sv
// ----------------------------------------------------------------------------
// tpc_ctrl
// Sequencer: steps the shared multiplier and divider for one item at a time.
// ----------------------------------------------------------------------------
module tpc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tpc_pkg::status_type status,
   output tpc_pkg::cmd_type   cmd
);

   tpc_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic accept;

   assign accept    = req_valid && (state_ff == tpc_pkg::ST_IDLE);
   assign req_stall = (state_ff != tpc_pkg::ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.needs_pos ? tpc_pkg::ST_MUL : tpc_pkg::ST_SEC_LOAD;
            end
         end
         tpc_pkg::ST_MUL: begin
            if (status.mul_last) state_in = tpc_pkg::ST_DIV_LOAD;
         end
         tpc_pkg::ST_DIV_LOAD: state_in = tpc_pkg::ST_DIV_POS;
         tpc_pkg::ST_DIV_POS: begin
            if (status.div_last) state_in = tpc_pkg::ST_RND_POS;
         end
         tpc_pkg::ST_RND_POS:  state_in = tpc_pkg::ST_CMT_POS;
         tpc_pkg::ST_CMT_POS:  state_in = tpc_pkg::ST_SEC_LOAD;
         tpc_pkg::ST_SEC_LOAD: state_in = tpc_pkg::ST_DIV_SEC;
         tpc_pkg::ST_DIV_SEC: begin
            if (status.div_last) state_in = tpc_pkg::ST_RND_SEC;
         end
         tpc_pkg::ST_RND_SEC:  state_in = tpc_pkg::ST_PUSH;
         tpc_pkg::ST_PUSH: begin
            if (!out_valid_ff || !rsp_stall) state_in = tpc_pkg::ST_IDLE;
         end
         default: state_in = tpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.load         = accept;
      cmd.mul_step     = (state_ff == tpc_pkg::ST_MUL);
      cmd.div_load_pos = (state_ff == tpc_pkg::ST_DIV_LOAD);
      cmd.sec_load     = (state_ff == tpc_pkg::ST_SEC_LOAD);
      cmd.div_step     = (state_ff == tpc_pkg::ST_DIV_POS) || (state_ff == tpc_pkg::ST_DIV_SEC);
      cmd.round        = (state_ff == tpc_pkg::ST_RND_POS) || (state_ff == tpc_pkg::ST_RND_SEC);
      cmd.pos_commit   = (state_ff == tpc_pkg::ST_CMT_POS);
      cmd.out_load     = (state_ff == tpc_pkg::ST_PUSH) && (!out_valid_ff || !rsp_stall);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> src/tpc_datapath.sv
// ----------------------------------------------------------------------------
// tpc_datapath
// Clock state, settings, a 32x32 partial-product multiplier and a restoring
// divider that rounds to nearest and saturates.
// ----------------------------------------------------------------------------
module tpc_datapath #(
   parameter int POS_FRAC_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [24:0]        csr_write_data,
   input  logic [1:0]         req_func,
   input  logic [31:0]        req_frames,
   input  logic [63:0]        req_seek_sample,
   input  logic [63:0]        req_seek_position,
   output logic [62:0]        rsp_sample_count,
   output logic [63:0]        rsp_beat_position,
   output logic [63:0]        rsp_timeline_seconds,
   output logic               rsp_running,
   input  tpc_pkg::cmd_type   cmd,
   output tpc_pkg::status_type status
);

   localparam int TEMPO_SHIFT = POS_FRAC_BITS - 16;

   logic [17:0]  rate_ff;
   logic [24:0]  tempo_ff;
   logic         run_ff;
   logic [62:0]  sc_ff, sc_in;
   logic [63:0]  qpos_ff, qpos_in;
   tpc_pkg::func_type func_ff;
   logic [63:0]  a_ff, b_ff;
   logic [127:0] prod_ff;
   logic [1:0]   mcnt_ff;
   logic [127:0] dvd_ff;
   logic [63:0]  dvs_ff, rem_ff, cap_ff, res_ff;
   logic [127:0] quot_ff;
   logic [6:0]   dcnt_ff;

   logic [63:0]  scaled_tempo;
   logic [23:0]  rate60;
   logic [62:0]  seek_s, seek_p_lo;
   logic [63:0]  seek_p;
   logic [63:0]  sc_sum;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [6:0]   shamt;
   logic [63:0]  rem_shift;
   logic         ge;
   logic         rnd;
   logic [127:0] q_rnd;
   logic [64:0]  pos_sum;
   tpc_pkg::func_type req_fn;

   assign req_fn       = tpc_pkg::func_type'(req_func);
   assign scaled_tempo = {39'd0, tempo_ff} << TEMPO_SHIFT;
   assign rate60       = ({6'd0, rate_ff} << 6) - ({6'd0, rate_ff} << 2);
   assign seek_s       = req_seek_sample[63] ? '0 : req_seek_sample[62:0];
   assign seek_p_lo    = req_seek_position[63] ? '0 : req_seek_position[62:0];
   assign seek_p       = {1'b0, seek_p_lo};
   assign sc_sum       = {1'b0, sc_ff} + {32'd0, req_frames};

   assign status.needs_pos = ((req_fn == tpc_pkg::FUNC_ADVANCE) && run_ff && (req_frames != '0))
                             || (req_fn == tpc_pkg::FUNC_SEEK_SAMPLE)
                             || (req_fn == tpc_pkg::FUNC_SEEK_POS);
   assign status.mul_last  = (mcnt_ff == 2'd3);
   assign status.div_last  = (dcnt_ff == 7'd127);

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= tpc_pkg::RATE_RESET;
         tempo_ff <= tpc_pkg::TEMPO_RESET;
         run_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tpc_pkg::CSR_SAMPLE_RATE: begin
               if (csr_write_data[17:0] >= tpc_pkg::RATE_MIN &&
                   csr_write_data[17:0] <= tpc_pkg::RATE_MAX) rate_ff <= csr_write_data[17:0];
            end
            tpc_pkg::CSR_TEMPO: begin
               if (csr_write_data >= tpc_pkg::TEMPO_MIN &&
                   csr_write_data <= tpc_pkg::TEMPO_MAX) tempo_ff <= csr_write_data;
            end
            tpc_pkg::CSR_RUN: run_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // multiplier: one 32x32 partial product per cycle
   assign a_half = mcnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = mcnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp     = a_half * b_half;
   assign shamt  = {({1'b0, mcnt_ff[1]} + {1'b0, mcnt_ff[0]}), 5'd0};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_fn;
         prod_ff <= '0;
         mcnt_ff <= 2'd0;
         case (req_fn)
            tpc_pkg::FUNC_SEEK_SAMPLE: begin
               a_ff <= {1'b0, seek_s};
               b_ff <= scaled_tempo;
            end
            tpc_pkg::FUNC_SEEK_POS: begin
               a_ff <= seek_p;
               b_ff <= {40'd0, rate60};
            end
            default: begin
               a_ff <= {32'd0, req_frames};
               b_ff <= scaled_tempo;
            end
         endcase
      end else if (cmd.mul_step) begin
         prod_ff <= prod_ff + ({64'd0, pp} << shamt);
         mcnt_ff <= mcnt_ff + 2'd1;
      end
   end

   // divider: one quotient bit per cycle
   assign rem_shift = {rem_ff[62:0], dvd_ff[127]};
   assign ge        = (rem_shift >= dvs_ff);
   assign rnd       = ({rem_ff, 1'b0} >= {1'b0, dvs_ff});
   assign q_rnd     = quot_ff + {127'd0, rnd};

   always_ff @(posedge clock) begin
      if (cmd.div_load_pos) begin
         dvd_ff  <= prod_ff;
         dvs_ff  <= (func_ff == tpc_pkg::FUNC_SEEK_POS) ? scaled_tempo : {40'd0, rate60};
         cap_ff  <= (func_ff == tpc_pkg::FUNC_SEEK_POS) ? {1'b0, tpc_pkg::MAX63} : tpc_pkg::ALL64;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.sec_load) begin
         dvd_ff  <= {33'd0, sc_ff, 32'd0};
         dvs_ff  <= {46'd0, rate_ff};
         cap_ff  <= tpc_pkg::ALL64;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[126:0], 1'b0};
         rem_ff  <= ge ? (rem_shift - dvs_ff) : rem_shift;
         quot_ff <= {quot_ff[126:0], ge};
         dcnt_ff <= dcnt_ff + 7'd1;
      end
      if (cmd.round) begin
         res_ff <= ((q_rnd[127:64] != '0) || (q_rnd[63:0] > cap_ff)) ? cap_ff : q_rnd[63:0];
      end
   end

   // clock state
   assign pos_sum = {1'b0, qpos_ff} + {1'b0, res_ff};

   always_comb begin
      sc_in   = sc_ff;
      qpos_in = qpos_ff;
      if (cmd.load) begin
         case (req_fn)
            tpc_pkg::FUNC_ADVANCE: begin
               if (run_ff && req_frames != '0) sc_in = sc_sum[63] ? tpc_pkg::MAX63 : sc_sum[62:0];
            end
            tpc_pkg::FUNC_SEEK_SAMPLE: sc_in   = seek_s;
            tpc_pkg::FUNC_SEEK_POS:    qpos_in = seek_p;
            default: ;
         endcase
      end else if (cmd.pos_commit) begin
         case (func_ff)
            tpc_pkg::FUNC_ADVANCE:     qpos_in = pos_sum[64] ? tpc_pkg::ALL64 : pos_sum[63:0];
            tpc_pkg::FUNC_SEEK_SAMPLE: qpos_in = res_ff;
            tpc_pkg::FUNC_SEEK_POS:    sc_in   = res_ff[62:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff   <= '0;
         qpos_ff <= '0;
      end else begin
         sc_ff   <= sc_in;
         qpos_ff <= qpos_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sample_count     <= sc_ff;
         rsp_beat_position    <= qpos_ff;
         rsp_timeline_seconds <= res_ff;
         rsp_running          <= run_ff;
      end
   end

endmodule

>>> src/transport_position_clock.sv
// ----------------------------------------------------------------------------
// transport_position_clock
// Audio transport clock keeping a sample count and a quarter-note position.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid/req_stall, func, frames, seeks | in
//  rsp     | rsp_valid/rsp_stall, count, pos, secs    | out
//  csr     | csr_write_enable, csr_index, data        | in
//
// an item that moves the position takes 4 multiplier steps, then 128 divider
// steps for the position and 128 for the seconds
// an item that leaves the position alone runs the seconds division only
// the single shared divider works out one quotient bit a cycle
// reset is synchronous; the result register lets the next item enter while
// a finished beat still waits on rsp_stall
// ----------------------------------------------------------------------------
module transport_position_clock #(
   parameter int POS_FRAC_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_frames,
   input  logic [63:0] req_seek_sample,
   input  logic [63:0] req_seek_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [62:0] rsp_sample_count,
   output logic [63:0] rsp_beat_position,
   output logic [63:0] rsp_timeline_seconds,
   output logic        rsp_running
);

   tpc_pkg::cmd_type    cmd;
   tpc_pkg::status_type status;

   tpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tpc_datapath #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_func             (req_func),
      .req_frames           (req_frames),
      .req_seek_sample      (req_seek_sample),
      .req_seek_position    (req_seek_position),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_beat_position    (rsp_beat_position),
      .rsp_timeline_seconds (rsp_timeline_seconds),
      .rsp_running          (rsp_running),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

>>> src/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks for the transport position clock, bound to the top level.
// ----------------------------------------------------------------------------
module tpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [62:0] rsp_sample_count,
   input logic [63:0] rsp_beat_position,
   input logic [63:0] rsp_timeline_seconds
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_count) &&
      $stable(rsp_beat_position) && $stable(rsp_timeline_seconds))
      else $error("stalled rsp beat changed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // one item at a time: busy after an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken while busy");

   // a result needs the multiplier or divider steps after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 req_stall)
      else $error("item finished too early");

endmodule

bind transport_position_clock tpc_checker u_tpc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_sample_count     (rsp_sample_count),
   .rsp_beat_position    (rsp_beat_position),
   .rsp_timeline_seconds (rsp_timeline_seconds)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the transport position clock: a directed table of beats, then random
// advance and seek traffic, predicted per beat and compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = tpc_pkg::CSR_SAMPLE_RATE;
   logic [24:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = tpc_pkg::FUNC_ADVANCE;
   logic [31:0] req_frames = '0;
   logic [63:0] req_seek_sample = '0;
   logic [63:0] req_seek_position = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [62:0] rsp_sample_count;
   logic [63:0] rsp_beat_position;
   logic [63:0] rsp_timeline_seconds;
   logic        rsp_running;

   transport_position_clock u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic [62:0] count;
      logic [63:0] pos;
      logic [63:0] secs;
      logic        run;
   } snapshot_type;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] frames;
      logic [63:0] seek_s;
      logic [63:0] seek_p;
      bit          typed;
      logic [62:0] count;
      logic [63:0] pos;
   } row_type;

   snapshot_type pending_snaps[$];
   int          error_count = 0;
   logic [17:0] model_rate;
   logic [24:0] model_tempo;
   logic        model_run;
   logic [62:0] model_count;
   logic [63:0] model_pos;
   bit          quiet_rx = 0;
   bit          long_hold = 1'b0;
   event        hold_start;

   function automatic logic [63:0] round_div(logic [127:0] num, logic [63:0] den,
                                             logic [63:0] cap);
      logic [127:0] q;
      logic [127:0] r;
      q = num / den;
      r = num % den;
      if (2 * r >= den) q = q + 1;
      if (q > cap) return cap;
      return q[63:0];
   endfunction

   function automatic logic [63:0] beats_of(logic [63:0] samples);
      logic [127:0] prod;
      prod = 128'(samples) * 128'({model_tempo, 16'd0});
      return round_div(prod, 64'(60 * model_rate), tpc_pkg::ALL64);
   endfunction

   function automatic snapshot_type predict_clock(logic [1:0] f, logic [31:0] fr,
                                                  logic [63:0] ss, logic [63:0] sp);
      snapshot_type s;
      logic [63:0] step;
      logic [64:0] sum;
      logic [63:0] v;
      logic [63:0] cnt;
      case (f)
         tpc_pkg::FUNC_ADVANCE: begin
            if (model_run && fr != 0) begin
               if (model_count > tpc_pkg::MAX63 - 63'(fr)) model_count = tpc_pkg::MAX63;
               else model_count = model_count + 63'(fr);
               step = beats_of(64'(fr));
               sum = 65'(model_pos) + 65'(step);
               model_pos = sum[64] ? tpc_pkg::ALL64 : sum[63:0];
            end
         end
         tpc_pkg::FUNC_SEEK_SAMPLE: begin
            v = ss[63] ? 64'd0 : ss;
            model_count = v[62:0];
            model_pos = beats_of(v);
         end
         tpc_pkg::FUNC_SEEK_POS: begin
            v = sp[63] ? 64'd0 : sp;
            model_pos = v;
            cnt = round_div(128'(v) * 128'(60 * model_rate),
                            64'({model_tempo, 16'd0}), 64'(tpc_pkg::MAX63));
            model_count = cnt[62:0];
         end
         default: ;
      endcase
      s.count = model_count;
      s.pos = model_pos;
      s.secs = round_div(128'({model_count, 32'd0}), 64'(model_rate), tpc_pkg::ALL64);
      s.run = model_run;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("tb_top: %s mismatch got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // long receiver hold-off, counted here
   initial forever begin
      @(hold_start);
      long_hold <= 1'b1;
      repeat (3000) @(posedge clock);
      long_hold <= 1'b0;
   end

   // receiver: own stall pattern, plus the long hold-off
   always @(posedge clock) begin
      snapshot_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_snaps.size() == 0) begin
            report_mismatch("unexpected beat", 64'(rsp_sample_count), 64'd0);
         end else begin
            e = pending_snaps.pop_front();
            if (rsp_sample_count !== e.count)
               report_mismatch("sample_count", 64'(rsp_sample_count), 64'(e.count));
            if (rsp_beat_position !== e.pos)
               report_mismatch("beat_position", rsp_beat_position, e.pos);
            if (rsp_timeline_seconds !== e.secs)
               report_mismatch("timeline_seconds", rsp_timeline_seconds, e.secs);
            if (rsp_running !== e.run)
               report_mismatch("running", 64'(rsp_running), 64'(e.run));
         end
      end
      if (long_hold) begin
         rsp_stall <= 1'b1;
      end else if (quiet_rx) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [24:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         tpc_pkg::CSR_SAMPLE_RATE:
            if (val[17:0] >= tpc_pkg::RATE_MIN && val[17:0] <= tpc_pkg::RATE_MAX)
               model_rate = val[17:0];
         tpc_pkg::CSR_TEMPO:
            if (val >= tpc_pkg::TEMPO_MIN && val <= tpc_pkg::TEMPO_MAX) model_tempo = val;
         tpc_pkg::CSR_RUN: model_run = val[0];
         default: ;
      endcase
   endtask

   task automatic drain_all();
      while (pending_snaps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // one beat on the request side; valid stays high across back-to-back beats
   task automatic send_item(logic [1:0] f, logic [31:0] fr, logic [63:0] ss,
                            logic [63:0] sp, bit gap_after);
      req_valid <= 1'b1;
      req_func <= f;
      req_frames <= fr;
      req_seek_sample <= ss;
      req_seek_position <= sp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_snaps.push_back(predict_clock(f, fr, ss, sp));
      if (gap_after) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   row_type directed[$];

   task automatic add_row(logic [1:0] f, logic [31:0] fr, logic [63:0] ss,
                          logic [63:0] sp, bit typed, logic [62:0] c, logic [63:0] p);
      row_type r;
      r = '{f, fr, ss, sp, typed, c, p};
      directed.push_back(r);
   endtask

   task automatic random_phase(int n);
      int burst;
      int k;
      logic [1:0] f;
      logic [31:0] fr;
      logic [63:0] ss;
      logic [63:0] sp;
      k = 0;
      while (k < n) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && k < n; b++) begin
            f = 2'($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
            case ($urandom_range(0, 4))
               0: fr = $urandom();
               1: fr = 32'hFFFF_FFFF;
               2: fr = '0;
               default: fr = $urandom_range(1, 4096);
            endcase
            case ($urandom_range(0, 3))
               0: ss = rand64();
               1: ss = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
               default: ss = {32'd0, $urandom()};
            endcase
            case ($urandom_range(0, 3))
               0: sp = rand64();
               1: sp = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF, $urandom()};
               default: sp = {16'd0, 16'($urandom_range(0, 65535)), $urandom()};
            endcase
            send_item(f, fr, ss, sp, b == burst - 1 || k == n - 1);
            k++;
         end
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      row_type r;
      model_rate = tpc_pkg::RATE_RESET;
      model_tempo = tpc_pkg::TEMPO_RESET;
      model_run = 1'b0;
      model_count = '0;
      model_pos = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: after reset, while stopped: extremes and seeks
      add_row(tpc_pkg::FUNC_ADVANCE, 32'd1000, '0, '0, 1, 63'd0, 64'd0);
      add_row(tpc_pkg::FUNC_NONE, '0, '0, '0, 1, 63'd0, 64'd0);
      add_row(tpc_pkg::FUNC_SEEK_SAMPLE, '0, 64'h8000_0000_0000_0000, '0, 1, 63'd0, 64'd0);
      add_row(tpc_pkg::FUNC_SEEK_POS, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 63'd0, 64'd0);
      // 48000 samples at 120 bpm is two quarter notes
      add_row(tpc_pkg::FUNC_SEEK_SAMPLE, '0, 64'd48000, '0, 1, 63'd48000, 64'h2_0000_0000);
      add_row(tpc_pkg::FUNC_SEEK_POS, '0, '0, 64'h1_0000_0000, 1, 63'd24000,
              64'h1_0000_0000);
      add_row(tpc_pkg::FUNC_SEEK_SAMPLE, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, 0, '0, '0);
      add_row(tpc_pkg::FUNC_SEEK_POS, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF, 0, '0, '0);
      add_row(tpc_pkg::FUNC_SEEK_POS, '0, '0, 64'd1, 0, '0, '0);
      foreach (directed[i]) begin
         r = directed[i];
         send_item(r.func, r.frames, r.seek_s, r.seek_p, 1);
         if (r.typed && (pending_snaps[$].count !== r.count || pending_snaps[$].pos !== r.pos))
            report_mismatch("directed row", 64'(i), 64'(r.count));
      end
      drain_all();

      write_reg(tpc_pkg::CSR_RUN, 25'd1);
      write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'd7999);
      write_reg(tpc_pkg::CSR_TEMPO, 25'd26214401);
      write_reg(tpc_pkg::CSR_NONE, 25'h1FF_FFFF);
      send_item(tpc_pkg::FUNC_ADVANCE, 32'd0, '0, '0, 1);
      send_item(tpc_pkg::FUNC_ADVANCE, 32'd1, '0, '0, 1);
      send_item(tpc_pkg::FUNC_ADVANCE, 32'hFFFF_FFFF, '0, '0, 1);
      send_item(tpc_pkg::FUNC_SEEK_SAMPLE, '0, 64'h7FFF_FFFF_FFFF_FF00, '0, 1);
      send_item(tpc_pkg::FUNC_ADVANCE, 32'hFFFF_FFFF, '0, '0, 1);
      send_item(tpc_pkg::FUNC_SEEK_POS, '0, '0, 64'hFFFF_FFFF_0000_0000 >> 1, 1);
      send_item(tpc_pkg::FUNC_ADVANCE, 32'hFFFF_FFFF, '0, '0, 1);
      drain_all();

      // settings: extremes, run off and random values, walked as phases
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'(tpc_pkg::RATE_MIN));
               write_reg(tpc_pkg::CSR_TEMPO, tpc_pkg::TEMPO_MAX);
            end
            1: begin
               write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'(tpc_pkg::RATE_MAX));
               write_reg(tpc_pkg::CSR_TEMPO, tpc_pkg::TEMPO_MIN);
            end
            2: begin
               write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'(tpc_pkg::RATE_MIN));
               write_reg(tpc_pkg::CSR_TEMPO, tpc_pkg::TEMPO_MIN);
            end
            3: begin
               write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'(tpc_pkg::RATE_MAX));
               write_reg(tpc_pkg::CSR_TEMPO, tpc_pkg::TEMPO_MAX);
            end
            4: write_reg(tpc_pkg::CSR_RUN, 25'd0);
            default: begin
               write_reg(tpc_pkg::CSR_RUN, 25'h1FF_FFFF);
               write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'($urandom_range(8000, 192000)));
               write_reg(tpc_pkg::CSR_TEMPO, 25'($urandom_range(1310720, 26214400)));
            end
         endcase
         quiet_rx = (ph == 2);
         if (ph == 3) -> hold_start;
         random_phase(170);
         drain_all();
      end
      write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'h3_FFFF);
      write_reg(tpc_pkg::CSR_SAMPLE_RATE, 25'h1FC_0000 | 25'd44100);
      random_phase(20);
      drain_all();

      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
